// ===== rtl/core/vft_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vft_pkg;

  localparam int TABLE_ENTRIES = 12;
  localparam int SLOT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int LEN_W = 12;
  localparam int ADDR_W = 48;
  localparam int CNT_W = 32;
  localparam int OUI_W = 24;

  localparam logic [7:0] FC_ACTION = 8'hD0;
  localparam logic [7:0] CAT_VENDOR = 8'h7F;
  localparam logic [OUI_W-1:0] OUI_WANTED = {8'h18, 8'hFE, 8'h34};
  localparam int HDR_BYTES = 39;
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(HDR_BYTES + 12 + 16);

  localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(TABLE_ENTRIES);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic go;
    logic ok;
    logic scan_end;
    logic hit;
  } ctl_in_t;

  typedef struct packed {
    logic busy;
    logic step;
    logic done_reject;
    logic done_hit;
    logic done_miss;
  } ctl_out_t;

  typedef struct packed {
    logic              en;
    logic              set_addr;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  count;
  } tbl_wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/vendor_frame_source_tally.sv =====
// An accepted frame is scanned through the table, one slot compared per cycle through a single
// 48-bit comparator; a rejected frame ends the scan before any slot is compared, a hit at slot i
// ends it there and a miss ends it after all known sources. The result strobe is registered.
// A new frame is taken only once busy has dropped after the last result; the receiver cannot stall.
// Synchronous active-low reset clears the raw frame counter and the fill count, restores the
// minimum length to 67, and leaves the table contents undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module vendor_frame_source_tally (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_is_management,
  input  wire logic [vft_pkg::LEN_W-1:0]     in_frame_length,
  input  wire logic [7:0]                    in_frame_control,
  input  wire logic [7:0]                    in_action_category,
  input  wire logic [vft_pkg::OUI_W-1:0]     in_vendor_oui,
  input  wire logic [vft_pkg::ADDR_W-1:0]    in_source_address,
  output logic                               out_valid,
  output logic                               out_accepted,
  output logic      [vft_pkg::CNT_W-1:0]     out_raw_total,
  output logic      [vft_pkg::SLOT_W-1:0]    out_matched_slot,
  output logic      [vft_pkg::CNT_W-1:0]     out_slot_frames,
  output logic      [vft_pkg::SLOT_W-1:0]    out_sources_known,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [vft_pkg::LEN_W-1:0]     cfg_data
);

  logic [vft_pkg::LEN_W-1:0]  min_len_r;
  logic                       ok_r;
  logic [vft_pkg::ADDR_W-1:0] sa_r;
  logic [vft_pkg::SLOT_W-1:0] idx_r;
  logic [vft_pkg::SLOT_W-1:0] idx_nxt;
  logic [vft_pkg::SLOT_W-1:0] used_r;
  logic [vft_pkg::CNT_W-1:0]  raw_r;
  logic                       out_valid_r;
  logic                       out_accepted_r;
  logic [vft_pkg::CNT_W-1:0]  out_raw_total_r;
  logic [vft_pkg::SLOT_W-1:0] out_matched_slot_r;
  logic [vft_pkg::CNT_W-1:0]  out_slot_frames_r;
  logic [vft_pkg::SLOT_W-1:0] out_sources_known_r;

  logic                       go;
  logic                       ok_nxt;
  logic [vft_pkg::ADDR_W-1:0] rd_addr;
  logic [vft_pkg::CNT_W-1:0]  rd_count;
  logic [vft_pkg::CNT_W-1:0]  count_inc;
  logic [vft_pkg::CNT_W-1:0]  raw_inc;
  logic                       has_room;
  vft_pkg::ctl_in_t           ci;
  vft_pkg::ctl_out_t          co;
  vft_pkg::tbl_wr_t           wr;

  assign cfg_ready = 1'b1;
  assign go = start && !co.busy;
  assign busy = co.busy;

  assign ok_nxt = in_is_management && (in_frame_length >= min_len_r) &&
                  (in_frame_control == vft_pkg::FC_ACTION) &&
                  (in_action_category == vft_pkg::CAT_VENDOR) &&
                  (in_vendor_oui == vft_pkg::OUI_WANTED);

  assign count_inc = rd_count + vft_pkg::CNT_W'(1);
  assign raw_inc   = raw_r + vft_pkg::CNT_W'(1);
  assign has_room  = used_r < vft_pkg::NO_SLOT;

  assign ci.go       = go;
  assign ci.ok       = ok_r;
  assign ci.scan_end = (idx_r == used_r);
  assign ci.hit      = (rd_addr == sa_r);

  vft_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .ci    (ci),
    .co    (co)
  );

  always_comb begin
    wr          = '0;
    wr.addr     = sa_r;
    if (co.done_hit) begin
      wr.en    = 1'b1;
      wr.idx   = idx_r[vft_pkg::IDX_W-1:0];
      wr.count = count_inc;
    end else if (co.done_miss && has_room) begin
      wr.en       = 1'b1;
      wr.set_addr = 1'b1;
      wr.idx      = used_r[vft_pkg::IDX_W-1:0];
      wr.count    = vft_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (go) begin
      idx_nxt = '0;
    end else if (co.step) begin
      idx_nxt = idx_r + vft_pkg::SLOT_W'(1);
    end
  end

  vft_table u_table (
    .clk      (clk),
    .wr       (wr),
    .rd_idx   (idx_nxt[vft_pkg::IDX_W-1:0]),
    .rd_addr  (rd_addr),
    .rd_count (rd_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r   <= vft_pkg::LEN_RESET;
      used_r      <= '0;
      raw_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        min_len_r <= cfg_data;
      end
      out_valid_r <= co.done_reject || co.done_hit || co.done_miss;
      if (co.done_hit || co.done_miss) begin
        raw_r <= raw_inc;
      end
      if (co.done_miss && has_room) begin
        used_r <= used_r + vft_pkg::SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ok_r  <= ok_nxt;
      sa_r  <= in_source_address;
    end
    idx_r <= idx_nxt;
    if (co.done_reject) begin
      out_accepted_r      <= 1'b0;
      out_raw_total_r     <= raw_r;
      out_matched_slot_r  <= vft_pkg::NO_SLOT;
      out_slot_frames_r   <= '0;
      out_sources_known_r <= used_r;
    end else if (co.done_hit) begin
      out_accepted_r      <= 1'b1;
      out_raw_total_r     <= raw_inc;
      out_matched_slot_r  <= idx_r;
      out_slot_frames_r   <= count_inc;
      out_sources_known_r <= used_r;
    end else if (co.done_miss) begin
      out_accepted_r  <= 1'b1;
      out_raw_total_r <= raw_inc;
      if (has_room) begin
        out_matched_slot_r  <= used_r;
        out_slot_frames_r   <= vft_pkg::CNT_W'(1);
        out_sources_known_r <= used_r + vft_pkg::SLOT_W'(1);
      end else begin
        out_matched_slot_r  <= vft_pkg::NO_SLOT;
        out_slot_frames_r   <= '0;
        out_sources_known_r <= used_r;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_accepted_r;
  assign out_raw_total     = out_raw_total_r;
  assign out_matched_slot  = out_matched_slot_r;
  assign out_slot_frames   = out_slot_frames_r;
  assign out_sources_known = out_sources_known_r;

endmodule

`default_nettype wire

// ===== rtl/core/vft_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vft_table (
  input  wire logic                        clk,
  input  wire vft_pkg::tbl_wr_t            wr,
  input  wire logic [vft_pkg::IDX_W-1:0]   rd_idx,
  output logic      [vft_pkg::ADDR_W-1:0]  rd_addr,
  output logic      [vft_pkg::CNT_W-1:0]   rd_count
);

  logic [vft_pkg::ADDR_W-1:0] addr_mem [vft_pkg::TABLE_ENTRIES];
  logic [vft_pkg::CNT_W-1:0]  count_mem [vft_pkg::TABLE_ENTRIES];
  logic [vft_pkg::ADDR_W-1:0] rd_addr_r;
  logic [vft_pkg::CNT_W-1:0]  rd_count_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      count_mem[wr.idx] <= wr.count;
      if (wr.set_addr) begin
        addr_mem[wr.idx] <= wr.addr;
      end
    end
    rd_addr_r  <= addr_mem[rd_idx];
    rd_count_r <= count_mem[rd_idx];
  end

  assign rd_addr  = rd_addr_r;
  assign rd_count = rd_count_r;

endmodule

`default_nettype wire

// ===== rtl/core/vft_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vft_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire vft_pkg::ctl_in_t  ci,
  output vft_pkg::ctl_out_t      co
);

  vft_pkg::state_t state_r;
  vft_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vft_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vft_pkg::ST_IDLE: begin
        if (ci.go) begin
          state_nxt = vft_pkg::ST_SCAN;
        end
      end
      vft_pkg::ST_SCAN: begin
        if (!ci.ok || ci.scan_end || ci.hit) begin
          state_nxt = vft_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vft_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    co = '0;
    unique case (state_r)
      vft_pkg::ST_IDLE: begin
        co = '0;
      end
      vft_pkg::ST_SCAN: begin
        co.busy = 1'b1;
        if (!ci.ok) begin
          co.done_reject = 1'b1;
        end else if (ci.scan_end) begin
          co.done_miss = 1'b1;
        end else if (ci.hit) begin
          co.done_hit = 1'b1;
        end else begin
          co.step = 1'b1;
        end
      end
      default: co = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/vft_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vft_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        out_valid,
  input wire logic                        out_accepted,
  input wire logic [vft_pkg::SLOT_W-1:0]  out_matched_slot,
  input wire logic [vft_pkg::CNT_W-1:0]   out_slot_frames,
  input wire logic [vft_pkg::SLOT_W-1:0]  out_sources_known
);

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("transfer accepted but block did not become busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("item finished without a result");

  a_reject_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |->
      out_matched_slot == vft_pkg::NO_SLOT && out_slot_frames == '0)
    else $error("rejected frame credited a slot");

  a_known_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sources_known <= vft_pkg::NO_SLOT)
    else $error("source count exceeds table size");

endmodule

bind vendor_frame_source_tally vft_checker u_vft_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_accepted      (out_accepted),
  .out_matched_slot  (out_matched_slot),
  .out_slot_frames   (out_slot_frames),
  .out_sources_known (out_sources_known)
);

`default_nettype wire
